// ===== src/rrpl_pkg.sv =====
package rrpl_pkg;

   localparam int unsigned DEFAULT_MAX_BUFFER_BYTES = 4096;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LEN_W  = 13;
   localparam int unsigned IDX_W  = 4;

   localparam int unsigned HEADER_LEN = 10;
   localparam int unsigned TOKEN_LEN  = 5;

   localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CH_D     = 8'h44;
   localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

   typedef enum logic [2:0] {
      PH_SEARCH,
      PH_SPACE,
      PH_TOKEN,
      PH_FIRST,
      PH_DIGITS,
      PH_EOL,
      PH_DONE,
      PH_FAIL
   } phase_type;

   typedef struct packed {
      phase_type              phase;
      logic [IDX_W-1:0]       match_index;
      logic [LEN_W-1:0]       length_acc;
      logic [LEN_W-1:0]       start_offset;
   } parse_state_type;

   localparam parse_state_type PARSE_STATE_RESET = '{
      phase:        PH_SEARCH,
      match_index:  '0,
      length_acc:   '0,
      start_offset: '0
   };

   // "+HTTPREAD:"
   function automatic logic [BYTE_W-1:0] header_char(input logic [IDX_W-1:0] idx);
      logic [BYTE_W-1:0] c;
      case (idx)
         4'd0:    c = 8'h2B;
         4'd1:    c = 8'h48;
         4'd2:    c = 8'h54;
         4'd3:    c = 8'h54;
         4'd4:    c = 8'h50;
         4'd5:    c = 8'h52;
         4'd6:    c = 8'h45;
         4'd7:    c = 8'h41;
         4'd8:    c = 8'h44;
         4'd9:    c = 8'h3A;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // "DATA,"
   function automatic logic [BYTE_W-1:0] token_char(input logic [IDX_W-1:0] idx);
      logic [BYTE_W-1:0] c;
      case (idx)
         4'd0:    c = 8'h44;
         4'd1:    c = 8'h41;
         4'd2:    c = 8'h54;
         4'd3:    c = 8'h41;
         4'd4:    c = 8'h2C;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ===== src/rrpl_parser.sv =====
module rrpl_parser #(
   parameter int unsigned MAX_BUFFER_BYTES = rrpl_pkg::DEFAULT_MAX_BUFFER_BYTES,
   localparam int unsigned POS_W = $clog2(MAX_BUFFER_BYTES + 1),
   localparam int unsigned CMP_W = (POS_W > rrpl_pkg::LEN_W) ? POS_W : rrpl_pkg::LEN_W
) (
   input  logic [rrpl_pkg::BYTE_W-1:0] data_byte,
   input  logic [CMP_W-1:0]            position,
   input  logic [CMP_W-1:0]            limit,
   input  rrpl_pkg::parse_state_type   cur_state,
   output rrpl_pkg::parse_state_type   next_state
);
   import rrpl_pkg::*;

   localparam int unsigned MUL_W = LEN_W + 4;
   localparam int unsigned SUM_W = (CMP_W > MUL_W) ? CMP_W : MUL_W;

   logic                  is_digit;
   logic [3:0]            digit;
   logic [SUM_W-1:0]      acc_times_ten;
   logic [SUM_W-1:0]      digit_sum;
   logic                  digit_over;
   logic [CMP_W-1:0]      position_inc;
   logic [IDX_W-1:0]      index_inc;

   assign is_digit      = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
   assign digit         = 4'(data_byte - CH_ZERO);
   // acc * 10 as two shifted copies
   assign acc_times_ten = (SUM_W'(cur_state.length_acc) << 3)
                        + (SUM_W'(cur_state.length_acc) << 1);
   assign digit_sum     = acc_times_ten + SUM_W'(digit);
   assign digit_over    = digit_sum > SUM_W'(limit);
   assign position_inc  = position + CMP_W'(1);
   assign index_inc     = cur_state.match_index + IDX_W'(1);

   always_comb begin
      next_state = cur_state;
      if (position < limit) begin
         case (cur_state.phase)
            PH_SEARCH: begin
               if (data_byte == header_char(cur_state.match_index)) begin
                  if (index_inc == IDX_W'(HEADER_LEN)) begin
                     next_state.match_index = '0;
                     next_state.phase       = PH_SPACE;
                  end else begin
                     next_state.match_index = index_inc;
                  end
               end else begin
                  next_state.match_index = (data_byte == CH_PLUS) ? IDX_W'(1) : '0;
               end
            end
            PH_SPACE: begin
               if (data_byte == CH_SPACE || data_byte == CH_TAB) begin
                  next_state.phase = PH_SPACE;
               end else if (data_byte == CH_D) begin
                  next_state.match_index = IDX_W'(1);
                  next_state.phase       = PH_TOKEN;
               end else if (is_digit) begin
                  if (digit_over) begin
                     next_state.phase = PH_FAIL;
                  end else begin
                     next_state.length_acc = digit_sum[LEN_W-1:0];
                     next_state.phase      = PH_DIGITS;
                  end
               end else begin
                  next_state.phase = PH_FAIL;
               end
            end
            PH_TOKEN: begin
               if (data_byte == token_char(cur_state.match_index)) begin
                  if (index_inc == IDX_W'(TOKEN_LEN)) begin
                     next_state.match_index = '0;
                     next_state.phase       = PH_FIRST;
                  end else begin
                     next_state.match_index = index_inc;
                  end
               end else begin
                  next_state.phase = PH_FAIL;
               end
            end
            PH_FIRST, PH_DIGITS: begin
               if (is_digit) begin
                  if (digit_over) begin
                     next_state.phase = PH_FAIL;
                  end else begin
                     next_state.length_acc = digit_sum[LEN_W-1:0];
                     next_state.phase      = PH_DIGITS;
                  end
               end else if (cur_state.phase == PH_FIRST) begin
                  next_state.phase = PH_FAIL;
               end else if (cur_state.length_acc == '0) begin
                  next_state.phase = PH_FAIL;
               end else if (data_byte == CH_NL) begin
                  next_state.start_offset = position_inc[LEN_W-1:0];
                  next_state.phase        = PH_DONE;
               end else begin
                  next_state.phase = PH_EOL;
               end
            end
            PH_EOL: begin
               if (data_byte == CH_NL) begin
                  next_state.start_offset = position_inc[LEN_W-1:0];
                  next_state.phase        = PH_DONE;
               end
            end
            default: begin
               next_state = cur_state;
            end
         endcase
      end
   end

endmodule

// ===== src/read_response_payload_locator_core.sv =====
// Locates the payload of a modem read response streamed in one byte per transaction.
// Each request carries a buffer byte, the buffer's total length and tlast on the final
// byte. The block finds the first "+HTTPREAD:" header, skips blanks, takes an optional
// "DATA," token and a nonzero decimal length no larger than the buffer, then waits for
// the line feed; the payload starts right after it. On the tlast byte one response
// comes out with found set when offset plus length fits in the buffer, else all zeros.
// Bytes at or past the buffer length (capped at MAX_BUFFER_BYTES) are not parsed.
// Throughput is one byte per clock while no tlast byte stalls, set by the per-byte parser
// state update; a response is registered once its tlast byte leaves the input register. Input
// stays open while a response waits; only a second tlast byte stalls until the pending response is taken.
module read_response_payload_locator_core #(
   parameter int unsigned MAX_BUFFER_BYTES = rrpl_pkg::DEFAULT_MAX_BUFFER_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   // request stream, one buffer byte per transaction
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] data_byte, [20:8] buffer_length, [23:21] zero
   input  logic        req_tlast,   // last_byte
   // response stream, one transaction per buffer
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [12:0] payload_offset, [25:13] payload_length,
                                    // [31:26] zero
   output logic        rsp_tuser    // found
);
   import rrpl_pkg::*;

   localparam int unsigned POS_W = $clog2(MAX_BUFFER_BYTES + 1);
   localparam int unsigned CMP_W = (POS_W > LEN_W) ? POS_W : LEN_W;
   localparam int unsigned END_W = CMP_W + 1;

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]     in_byte_ff;
   logic [LEN_W-1:0]      in_len_ff;
   logic                  in_last_ff;

   // parser state
   logic [POS_W-1:0]      pos_ff, pos_in;
   parse_state_type       state_ff, state_in;
   parse_state_type       state_step;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  found_ff;
   logic [LEN_W-1:0]      offset_ff;
   logic [LEN_W-1:0]      length_ff;

   logic                  req_fire;
   logic                  step_fire;
   logic [CMP_W-1:0]      len_ext;
   logic [CMP_W-1:0]      max_ext;
   logic [CMP_W-1:0]      limit;
   logic [CMP_W-1:0]      pos_ext;
   logic [END_W-1:0]      pos_plus_one;
   logic [END_W-1:0]      buffer_end;
   logic [END_W-1:0]      payload_end;
   logic                  found;

   // a tlast byte can only move on once the result register is free
   assign step_fire  = in_valid_ff && !(in_last_ff && rsp_valid_ff && !rsp_tready);
   assign req_tready = !in_valid_ff || step_fire;
   assign req_fire   = req_tvalid && req_tready;

   // usable limit is the buffer length capped at the configured maximum
   assign len_ext = CMP_W'(in_len_ff);
   assign max_ext = CMP_W'(MAX_BUFFER_BYTES);
   assign limit   = (len_ext > max_ext) ? max_ext : len_ext;
   assign pos_ext = CMP_W'(pos_ff);

   rrpl_parser #(
      .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
   ) u_parser (
      .data_byte  (in_byte_ff),
      .position   (pos_ext),
      .limit      (limit),
      .cur_state  (state_ff),
      .next_state (state_step)
   );

   // buffer end is the bytes received, or the limit if that is smaller
   assign pos_plus_one = END_W'(pos_ext) + END_W'(1);
   assign buffer_end   = (pos_plus_one < END_W'(limit)) ? pos_plus_one : END_W'(limit);
   assign payload_end  = END_W'(state_step.start_offset) + END_W'(state_step.length_acc);
   assign found        = (state_step.phase == PH_DONE) && (state_step.length_acc != '0)
                         && (payload_end <= buffer_end);

   always_comb begin
      in_valid_in  = in_valid_ff;
      pos_in       = pos_ff;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (step_fire) begin
         in_valid_in = 1'b0;
         if (in_last_ff) begin
            // buffer closed: result out, parser back to its start state
            pos_in       = '0;
            state_in     = PARSE_STATE_RESET;
            rsp_valid_in = 1'b1;
         end else begin
            // position saturates; anything at or past the limit is ignored anyway
            pos_in   = (pos_ff == POS_W'(MAX_BUFFER_BYTES)) ? pos_ff : pos_ff + POS_W'(1);
            state_in = state_step;
         end
      end

      if (req_fire) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         pos_ff       <= '0;
         state_ff     <= PARSE_STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         pos_ff       <= pos_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_tdata[7:0];
         in_len_ff  <= req_tdata[20:8];
         in_last_ff <= req_tlast;
      end
      if (step_fire && in_last_ff) begin
         found_ff  <= found;
         offset_ff <= found ? state_step.start_offset : '0;
         length_ff <= found ? state_step.length_acc : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = found_ff;
   assign rsp_tdata  = {6'b0, length_ff, offset_ff};

endmodule

// ===== tb/read_response_payload_locator_core_test.sv =====
`timescale 1ns / 100ps

module read_response_payload_locator_core_test;
   import rrpl_pkg::*;

   // usable buffer limit, same as the block's default parameter
   localparam int unsigned MAX_BYTES   = DEFAULT_MAX_BUFFER_BYTES;
   // byte counter saturates here
   localparam logic [17:0] POS_CAP     = 18'h3FFFF;
   // generous bound on the whole run, in clock cycles
   localparam int unsigned CYCLE_LIMIT = 200000;
   // random request transactions per idling phase
   localparam int unsigned PHASE_ITEMS = 650;
   // long receiver hold-off, in cycles
   localparam int unsigned HOLD_CYCLES = 400;

   localparam string HEADER_TEXT = "+HTTPREAD:";
   localparam string TOKEN_TEXT  = "DATA,";

   typedef struct {
      logic [7:0]  data;
      logic [12:0] blen;
      logic        last;
   } buffer_byte_type;

   typedef struct {
      logic        found;
      logic [12:0] offset;
      logic [12:0] length;
   } payload_loc_type;

   // shapes of generated response buffers
   typedef enum {
      FRAME_GOOD,
      FRAME_TRUNCATED,
      FRAME_BAD_TOKEN,
      FRAME_NO_DIGITS,
      FRAME_ZERO_LEN,
      FRAME_UNTERMINATED,
      FRAME_OVERSIZE,
      FRAME_SHORT_LIMIT,
      FRAME_LONG_LIMIT,
      FRAME_NOISE
   } frame_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [7:0] data_byte, [20:8] buffer_length, [23:21] zero
   logic        req_tlast = 1'b0; // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [12:0] payload_offset, [25:13] payload_length, [31:26] zero
   logic        rsp_tuser;        // found

   // bytes waiting to be offered, and the locations the block owes us
   buffer_byte_type pending_bytes[$];
   payload_loc_type expected_locations[$];
   logic [7:0]      frame_bytes[$];

   // local copy of the parser state
   phase_type    scan_phase = PH_SEARCH;
   logic [3:0]   scan_match = '0;
   logic [17:0]  scan_pos = '0;
   logic [12:0]  decl_len = '0;
   logic [12:0]  payload_start = '0;

   int unsigned  send_idle_pct = 36;
   int unsigned  recv_idle_pct = 69;
   bit           hold_armed = 1'b0;
   bit           hold_done = 1'b0;
   int unsigned  hold_left = 0;
   int unsigned  cycle_count = 0;
   int unsigned  error_count = 0;
   int unsigned  queued_count = 0;
   int unsigned  accepted_count = 0;

   read_response_payload_locator_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // locator prediction
   // ---------------------------------------------------------------------

   function automatic bit is_digit(input logic [7:0] b);
      return b >= CH_ZERO && b <= CH_NINE;
   endfunction

   // one more length digit; too large for the buffer fails the parse
   task automatic add_digit(input logic [7:0] b, input logic [12:0] limit);
      logic [16:0] next_len;
      next_len = decl_len * 17'd10 + {9'd0, b - CH_ZERO};
      if (next_len > {4'd0, limit}) begin
         scan_phase = PH_FAIL;
      end else begin
         decl_len   = next_len[12:0];
         scan_phase = PH_DIGITS;
      end
   endtask

   task automatic clear_scan();
      scan_phase    = PH_SEARCH;
      scan_match    = '0;
      scan_pos      = '0;
      decl_len      = '0;
      payload_start = '0;
   endtask

   // advance the parser by one accepted byte, queue a location on the last byte
   task automatic track_byte(input logic [7:0] b, input logic [12:0] blen, input logic last);
      logic [12:0]     limit;
      logic [17:0]     pos;
      logic [17:0]     end_pos;
      payload_loc_type loc;
      limit = (blen > MAX_BYTES) ? 13'(MAX_BYTES) : blen;
      pos   = scan_pos;
      // bytes past the limit are counted but never parsed
      if (pos < {5'd0, limit}) begin
         case (scan_phase)
            PH_SEARCH: begin
               if (scan_match < 4'(HEADER_TEXT.len()) && b == HEADER_TEXT[scan_match]) begin
                  scan_match = scan_match + 4'd1;
                  if (scan_match == 4'(HEADER_TEXT.len())) begin
                     scan_match = '0;
                     scan_phase = PH_SPACE;
                  end
               end else begin
                  // a plus sign may start a fresh header
                  scan_match = (b == CH_PLUS) ? 4'd1 : 4'd0;
               end
            end
            PH_SPACE: begin
               if (b == CH_SPACE || b == CH_TAB) begin
               end else if (b == CH_D) begin
                  scan_match = 4'd1;
                  scan_phase = PH_TOKEN;
               end else if (is_digit(b)) begin
                  add_digit(b, limit);
               end else begin
                  scan_phase = PH_FAIL;
               end
            end
            PH_TOKEN: begin
               if (scan_match < 4'(TOKEN_TEXT.len()) && b == TOKEN_TEXT[scan_match]) begin
                  scan_match = scan_match + 4'd1;
                  if (scan_match == 4'(TOKEN_TEXT.len())) begin
                     scan_match = '0;
                     scan_phase = PH_FIRST;
                  end
               end else begin
                  scan_phase = PH_FAIL;
               end
            end
            PH_FIRST: begin
               if (is_digit(b)) begin
                  add_digit(b, limit);
               end else begin
                  scan_phase = PH_FAIL;
               end
            end
            PH_DIGITS: begin
               if (is_digit(b)) begin
                  add_digit(b, limit);
               end else if (decl_len == '0) begin
                  scan_phase = PH_FAIL;
               end else if (b == CH_NL) begin
                  payload_start = 13'(pos + 18'd1);
                  scan_phase    = PH_DONE;
               end else begin
                  scan_phase = PH_EOL;
               end
            end
            PH_EOL: begin
               if (b == CH_NL) begin
                  payload_start = 13'(pos + 18'd1);
                  scan_phase    = PH_DONE;
               end
            end
            default: begin
            end
         endcase
      end
      if (scan_pos < POS_CAP) scan_pos = scan_pos + 18'd1;
      if (last) begin
         // a buffer that ends early is only as long as what arrived
         end_pos = (pos + 18'd1 < {5'd0, limit}) ? pos + 18'd1 : {5'd0, limit};
         loc.found = scan_phase == PH_DONE && decl_len != '0 &&
                     18'(payload_start) + 18'(decl_len) <= end_pos;
         loc.offset = loc.found ? payload_start : 13'd0;
         loc.length = loc.found ? decl_len : 13'd0;
         expected_locations.push_back(loc);
         clear_scan();
      end
   endtask

   // ---------------------------------------------------------------------
   // buffer generation
   // ---------------------------------------------------------------------

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
   endtask

   // hand the assembled buffer to the driver, tlast on its final byte
   task automatic queue_frame(input logic [12:0] blen);
      buffer_byte_type item;
      for (int i = 0; i < frame_bytes.size(); i++) begin
         item.data = frame_bytes[i];
         item.blen = blen;
         item.last = (i == frame_bytes.size() - 1);
         pending_bytes.push_back(item);
      end
      queued_count += frame_bytes.size();
      frame_bytes.delete();
   endtask

   function automatic frame_kind_type pick_kind();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 45) return FRAME_GOOD;
      if (r < 53) return FRAME_TRUNCATED;
      if (r < 58) return FRAME_BAD_TOKEN;
      if (r < 63) return FRAME_NO_DIGITS;
      if (r < 67) return FRAME_ZERO_LEN;
      if (r < 72) return FRAME_UNTERMINATED;
      if (r < 77) return FRAME_OVERSIZE;
      if (r < 85) return FRAME_SHORT_LIMIT;
      if (r < 92) return FRAME_LONG_LIMIT;
      return FRAME_NOISE;
   endfunction

   task automatic build_frame(input frame_kind_type kind);
      int unsigned n;
      int unsigned cut;
      int unsigned idx;
      int unsigned size;
      logic [7:0]  c;
      logic [12:0] blen;
      frame_bytes.delete();
      if (kind == FRAME_NOISE) begin
         repeat ($urandom_range(1, 30)) frame_bytes.push_back(8'($urandom));
         blen = $urandom_range(1) ? 13'($urandom) : 13'(frame_bytes.size());
         queue_frame(blen);
      end else begin
         // chatter before the header, partial headers among it
         repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 3))
               0:       push_text("+HT");
               1:       push_text("+");
               2:       push_text("\r\nOK\r\n");
               default: frame_bytes.push_back(8'($urandom));
            endcase
         end
         push_text(HEADER_TEXT);
         repeat ($urandom_range(0, 3)) frame_bytes.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
         if (kind == FRAME_BAD_TOKEN) begin
            // break the token somewhere after its first letter
            idx = $urandom_range(1, 4);
            for (int i = 0; i < TOKEN_TEXT.len(); i++) begin
               c = TOKEN_TEXT[i];
               if (i == idx) c = c ^ 8'($urandom_range(1, 255));
               frame_bytes.push_back(c);
            end
         end else if ($urandom_range(1)) begin
            push_text(TOKEN_TEXT);
         end
         case (kind)
            FRAME_OVERSIZE: n = $urandom_range(100, 9999);
            FRAME_ZERO_LEN: n = 0;
            default:        n = ($urandom_range(7) == 0) ? $urandom_range(25, 200) :
                                                          $urandom_range(1, 24);
         endcase
         if (kind == FRAME_NO_DIGITS) begin
            case ($urandom_range(0, 2))
               0:       push_text("x");
               1:       push_text(",");
               default: frame_bytes.push_back(CH_NL);
            endcase
            n = $urandom_range(0, 5);
         end else begin
            if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) push_text("0");
            push_text($sformatf("%0d", n));
         end
         // extra text before the line feed sends the parser to its end-of-line wait
         if ($urandom_range(2) == 0) begin
            if ($urandom_range(1)) push_text("\r");
            else push_text(" ok\r");
         end
         if (kind == FRAME_UNTERMINATED) begin
            repeat ($urandom_range(0, 6)) begin
               c = 8'($urandom);
               frame_bytes.push_back(c == CH_NL ? 8'h0B : c);
            end
         end else begin
            push_text("\n");
            if (kind == FRAME_OVERSIZE) cut = $urandom_range(0, 8);
            else if (kind == FRAME_TRUNCATED && n > 0) cut = $urandom_range(0, n - 1);
            else cut = n;
            repeat (cut) frame_bytes.push_back(8'($urandom));
            if (kind != FRAME_TRUNCATED) repeat ($urandom_range(0, 2))
               frame_bytes.push_back(8'($urandom));
         end
         size = frame_bytes.size();
         case (kind)
            // bytes sent past the buffer length
            FRAME_SHORT_LIMIT: blen = 13'($urandom_range(1, size - 1));
            // buffer ends before its announced length, sometimes beyond the cap
            FRAME_LONG_LIMIT:  blen = 13'($urandom_range(size + 1, 8191));
            default:           blen = 13'(size);
         endcase
         queue_frame(blen);
      end
   endtask

   task automatic fill_random_phase();
      int unsigned stop_at;
      stop_at = queued_count + PHASE_ITEMS;
      while (queued_count < stop_at) build_frame(pick_kind());
   endtask

   // wait until every queued byte went in and every location came back
   task automatic wait_drained();
      while (accepted_count != queued_count || expected_locations.size() != 0)
         @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // request driver
   // ---------------------------------------------------------------------

   always @(posedge clock) begin : drive_requests
      buffer_byte_type next_byte;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         // channel free: offer the next byte unless idling this cycle
         if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_byte  = pending_bytes.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {3'd0, next_byte.blen, next_byte.data};
            req_tlast  <= next_byte.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // response receiver
   // ---------------------------------------------------------------------

   always @(posedge clock) begin : drive_ready
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_armed && !hold_done) begin
         // long hold-off so the block backs up and stalls its input
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------------
   // monitor: predict on each request transaction, check each response
   // ---------------------------------------------------------------------

   always @(posedge clock) begin : watch_channels
      payload_loc_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            track_byte(req_tdata[7:0], req_tdata[20:8], req_tlast);
            accepted_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_locations.size() == 0) begin
               $error("unexpected response transaction: found %0d offset %0d length %0d",
                      rsp_tuser, rsp_tdata[12:0], rsp_tdata[25:13]);
               error_count++;
            end else begin
               want = expected_locations.pop_front();
               if (rsp_tuser !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata[12:0] !== want.offset) begin
                  $error("payload_offset: expected %0d, actual %0d", want.offset,
                         rsp_tdata[12:0]);
                  error_count++;
               end
               if (rsp_tdata[25:13] !== want.length) begin
                  $error("payload_length: expected %0d, actual %0d", want.length,
                         rsp_tdata[25:13]);
                  error_count++;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // sequence of the run
   // ---------------------------------------------------------------------

   initial begin
      // directed: zero buffer length, all-ones length ending at once, minimal hit
      frame_bytes.push_back(8'hFF);
      queue_frame(13'd0);
      frame_bytes.push_back(8'h00);
      queue_frame(13'h1FFF);
      push_text("+HTTPREAD:1\n");
      frame_bytes.push_back(8'h5A);
      queue_frame(13'd13);

      // phase one: sender idles 36 percent, receiver 69 percent
      fill_random_phase();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait_drained();

      // phase two: the other way round
      send_idle_pct = 69;
      recv_idle_pct = 36;
      fill_random_phase();
      wait_drained();

      // phase three: no idling, opened by one long receiver hold-off
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_armed    = 1'b1;
      fill_random_phase();
      wait_drained();

      // let any stray response show up before judging
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
